// File: rtl/core/hid_kb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hid_kb_pkg
// Shared sizes, types and modifier code tables of the keyboard converter.
// ----------------------------------------------------------------------------
package hid_kb_pkg;

  localparam int KEY_SLOTS   = 6;
  localparam int FIELD_SLOTS = 6;
  localparam int MOD_BITS    = 8;
  localparam int TABLE_DEPTH = 256;

  localparam int KEY_W    = 8;
  localparam int CODE_W   = 8;
  localparam int ADDR_W   = $clog2(TABLE_DEPTH);
  localparam int MOD_IDX_W = $clog2(MOD_BITS);

  // make and break candidate per slot, in slot order
  localparam int KEY_CANDS = 2 * KEY_SLOTS;
  localparam int STEPS     = KEY_CANDS + MOD_BITS;
  localparam int PTR_W     = $clog2(STEPS + 1);
  localparam int CAND_W    = $clog2(KEY_CANDS);

  typedef enum logic {
    OP_REPORT = 1'b0,
    OP_LOAD   = 1'b1
  } kb_op_t;

  typedef logic [KEY_W-1:0] kb_key_t;

  typedef struct packed {
    logic                vld;
    logic [ADDR_W-1:0]   index;
    logic [CODE_W-1:0]   code;
    logic                ext;
  } kb_load_t;

  // left ctrl, shift, alt, gui, then right ctrl, shift, alt, gui
  function automatic logic [CODE_W-1:0] mod_code(input logic [MOD_IDX_W-1:0] m);
    logic [CODE_W-1:0] c;
    unique case (m)
      3'd0:    c = 8'h14;
      3'd1:    c = 8'h12;
      3'd2:    c = 8'h11;
      3'd3:    c = 8'h1f;
      3'd4:    c = 8'h14;
      3'd5:    c = 8'h59;
      3'd6:    c = 8'h11;
      default: c = 8'h27;
    endcase
    return c;
  endfunction

  function automatic logic mod_ext(input logic [MOD_IDX_W-1:0] m);
    logic e;
    unique case (m)
      3'd3, 3'd4, 3'd6, 3'd7: e = 1'b1;
      default:                e = 1'b0;
    endcase
    return e;
  endfunction

endpackage

// File: rtl/core/hid_kb_lane.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hid_kb_lane
// One slot lane: finds whether the slot's new key is a fresh press and
// whether its previous key has been released.
// ----------------------------------------------------------------------------
module hid_kb_lane
  import hid_kb_pkg::*;
(
  input  kb_key_t new_key,
  input  kb_key_t prev_key,
  input  kb_key_t new_keys  [KEY_SLOTS],
  input  kb_key_t prev_keys [KEY_SLOTS],
  output logic    make_hit,
  output logic    break_hit
);

  logic in_prev;
  logic in_new;

  always_comb begin
    in_prev = 1'b0;
    in_new  = 1'b0;
    for (int i = 0; i < KEY_SLOTS; i++) begin
      if (prev_keys[i] == new_key) in_prev = 1'b1;
      if (new_keys[i] == prev_key) in_new = 1'b1;
    end
  end

  assign make_hit  = (new_key != '0) && !in_prev;
  assign break_hit = (prev_key != '0) && !in_new;

endmodule

// File: rtl/core/hid_kb_walker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hid_kb_walker
// Merging stage: walks the lane candidates and modifier bits in order,
// translates keys through the table and emits events with the last flag.
// ----------------------------------------------------------------------------
module hid_kb_walker
  import hid_kb_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  kb_load_t          load,
  input  logic              cand_hit [KEY_CANDS],
  input  kb_key_t           cand_key [KEY_CANDS],
  input  logic [MOD_BITS-1:0] mods_now,
  input  logic [MOD_BITS-1:0] mods_was,
  output logic              busy,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [CODE_W-1:0] out_scan_code,
  output logic              out_extended,
  output logic              out_is_break,
  output logic              out_last
);

  // translation table, entries without valid bit read as unmapped
  logic [CODE_W:0]          tbl_mem [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0]   tbl_vld_r;

  logic                     cand_hit_r [KEY_CANDS];
  kb_key_t                  cand_key_r [KEY_CANDS];
  logic [MOD_BITS-1:0]      now_r;
  logic [MOD_BITS-1:0]      was_r;

  logic                     busy_r;
  logic [PTR_W-1:0]         ptr_r;

  // lookup stage
  logic                     b_vld_r;
  logic                     b_brk_r;
  logic                     b_mod_r;
  logic [CODE_W-1:0]        b_code_r;
  logic                     b_ext_r;
  logic [CODE_W:0]          rd_word_r;
  logic                     rd_ok_r;

  // one event held back until we know whether another follows
  logic                     pend_vld_r;
  logic [CODE_W-1:0]        pend_code_r;
  logic                     pend_ext_r;
  logic                     pend_brk_r;

  logic                     out_valid_r;
  logic [CODE_W-1:0]        out_code_r;
  logic                     out_ext_r;
  logic                     out_brk_r;
  logic                     out_last_r;

  logic                     walking;
  logic                     is_key_step;
  logic [CAND_W-1:0]        cand_idx;
  logic [MOD_IDX_W-1:0]     mod_idx;
  logic [PTR_W-1:0]         mod_off;
  logic [ADDR_W-1:0]        rd_addr;
  logic                     a_vld;
  logic                     a_brk;
  logic                     b_event;
  logic [CODE_W-1:0]        ev_code;
  logic                     ev_ext;
  logic                     out_free;
  logic                     advance;
  logic                     done;
  logic                     emit_mid;
  logic                     emit_last;

  assign walking     = busy_r && (ptr_r < PTR_W'(STEPS));
  assign is_key_step = ptr_r < PTR_W'(KEY_CANDS);
  assign cand_idx    = ptr_r[CAND_W-1:0];
  assign mod_off     = ptr_r - PTR_W'(KEY_CANDS);
  assign mod_idx     = mod_off[MOD_IDX_W-1:0];
  assign rd_addr     = cand_key_r[cand_idx][ADDR_W-1:0];

  always_comb begin
    if (is_key_step) begin
      a_vld = cand_hit_r[cand_idx];
      a_brk = cand_idx[0];
    end else begin
      a_vld = now_r[mod_idx] ^ was_r[mod_idx];
      a_brk = was_r[mod_idx];
    end
  end

  assign ev_code  = b_mod_r ? b_code_r : rd_word_r[CODE_W-1:0];
  assign ev_ext   = b_mod_r ? b_ext_r : rd_word_r[CODE_W];
  assign b_event  = b_vld_r && (b_mod_r || (rd_ok_r && (rd_word_r[CODE_W-1:0] != '0)));
  assign out_free = !out_valid_r || !out_stall;
  assign advance  = !(b_event && pend_vld_r && !out_free);
  assign done     = busy_r && !walking && !b_vld_r;

  // held event moves to the output: mid walk when a newer one is found,
  // or at the end of the walk as the last one
  assign emit_last = !start && done && pend_vld_r && out_free;
  assign emit_mid  = !start && !done && advance && b_event && pend_vld_r;

  always_ff @(posedge clk) begin
    if (load.vld) begin
      tbl_mem[load.index] <= {load.ext, load.code};
    end
    if (advance) begin
      rd_word_r <= tbl_mem[rd_addr];
      b_brk_r   <= a_brk;
      b_mod_r   <= !is_key_step;
      b_code_r  <= mod_code(mod_idx);
      b_ext_r   <= mod_ext(mod_idx);
    end
    if (start) begin
      cand_hit_r <= cand_hit;
      cand_key_r <= cand_key;
      now_r      <= mods_now;
      was_r      <= mods_was;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tbl_vld_r   <= '0;
      rd_ok_r     <= 1'b0;
      busy_r      <= 1'b0;
      ptr_r       <= '0;
      b_vld_r     <= 1'b0;
      pend_vld_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (load.vld) tbl_vld_r[load.index] <= 1'b1;
      if (advance) rd_ok_r <= tbl_vld_r[rd_addr];

      if (emit_mid || emit_last) out_valid_r <= 1'b1;
      else if (out_free) out_valid_r <= 1'b0;

      if (start) begin
        busy_r  <= 1'b1;
        ptr_r   <= '0;
        b_vld_r <= 1'b0;
      end else if (done) begin
        if (pend_vld_r) begin
          if (out_free) begin
            out_code_r  <= pend_code_r;
            out_ext_r   <= pend_ext_r;
            out_brk_r   <= pend_brk_r;
            out_last_r  <= 1'b1;
            pend_vld_r  <= 1'b0;
            busy_r      <= 1'b0;
          end
        end else begin
          busy_r <= 1'b0;
        end
      end else if (advance) begin
        if (walking) begin
          ptr_r   <= ptr_r + 1'b1;
          b_vld_r <= a_vld;
        end else begin
          b_vld_r <= 1'b0;
        end
        if (b_event) begin
          if (pend_vld_r) begin
            out_code_r  <= pend_code_r;
            out_ext_r   <= pend_ext_r;
            out_brk_r   <= pend_brk_r;
            out_last_r  <= 1'b0;
          end
          pend_vld_r  <= 1'b1;
          pend_code_r <= ev_code;
          pend_ext_r  <= ev_ext;
          pend_brk_r  <= b_brk_r;
        end
      end
    end
  end

  assign busy          = busy_r;
  assign out_valid     = out_valid_r;
  assign out_scan_code = out_code_r;
  assign out_extended  = out_ext_r;
  assign out_is_break  = out_brk_r;
  assign out_last      = out_last_r;

endmodule

// File: rtl/core/hid_keyboard_report_to_ps2_events.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hid_keyboard_report_to_ps2_events
// Turns boot keyboard reports into ps2 set 2 make and break events.
// ----------------------------------------------------------------------------
// The input channel carries either a report (six key slots and a modifier
// byte) or a load item that writes one entry of the key translation table.
// An item is taken when in_valid is high and in_stall low; in_stall is high
// while a report is still being walked. A load does not raise in_stall and
// gives no event.
// Each report is compared with the previous one by one lane per slot, then
// a sequencer steps through twelve slot candidates and eight modifier bits,
// one step per cycle while the walk is not paused, with a registered table
// lookup in between. A report holds the input stalled until its walk ends
// and any held event has moved to the output register. An event waits until
// the walk finds the next one or ends. The final event of a report has
// out_last set; a report with no change gives no event. Events wait in an
// output register while out_stall is high, and the walk pauses when it
// finds a new event while one more is pending behind it, which stretches
// the input stall by as much.
// Reset clears the previous report and marks every table entry unmapped
// at once, so the block takes items right after reset.
// ----------------------------------------------------------------------------
module hid_keyboard_report_to_ps2_events
  import hid_kb_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              in_opcode,
  input  logic [KEY_W-1:0]  in_key_slot_0,
  input  logic [KEY_W-1:0]  in_key_slot_1,
  input  logic [KEY_W-1:0]  in_key_slot_2,
  input  logic [KEY_W-1:0]  in_key_slot_3,
  input  logic [KEY_W-1:0]  in_key_slot_4,
  input  logic [KEY_W-1:0]  in_key_slot_5,
  input  logic [MOD_BITS-1:0] in_modifier_bits,
  input  logic [ADDR_W-1:0] in_entry_index,
  input  logic [CODE_W-1:0] in_entry_code,
  input  logic              in_entry_extended,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [CODE_W-1:0] out_scan_code,
  output logic              out_extended,
  output logic              out_is_break,
  output logic              out_last
);

  kb_key_t             field_keys [FIELD_SLOTS];
  kb_key_t             new_keys   [KEY_SLOTS];
  kb_key_t             prev_keys_r [KEY_SLOTS];
  logic [MOD_BITS-1:0] prev_mods_r;
  logic                cand_hit [KEY_CANDS];
  kb_key_t             cand_key [KEY_CANDS];
  logic                busy;
  logic                accept;
  logic                start;
  kb_load_t            load;

  assign field_keys[0] = in_key_slot_0;
  assign field_keys[1] = in_key_slot_1;
  assign field_keys[2] = in_key_slot_2;
  assign field_keys[3] = in_key_slot_3;
  assign field_keys[4] = in_key_slot_4;
  assign field_keys[5] = in_key_slot_5;

  assign in_stall = busy;
  assign accept   = in_valid && !busy;
  assign start    = accept && (kb_op_t'(in_opcode) == OP_REPORT);

  assign load.vld   = accept && (kb_op_t'(in_opcode) == OP_LOAD);
  assign load.index = in_entry_index;
  assign load.code  = in_entry_code;
  assign load.ext   = in_entry_extended;

  for (genvar g = 0; g < KEY_SLOTS; g++) begin : g_lane
    // slots past the report fields read as empty
    if (g < FIELD_SLOTS) begin : g_field
      assign new_keys[g] = field_keys[g];
    end else begin : g_empty
      assign new_keys[g] = '0;
    end

    hid_kb_lane u_lane (
      .new_key   (new_keys[g]),
      .prev_key  (prev_keys_r[g]),
      .new_keys  (new_keys),
      .prev_keys (prev_keys_r),
      .make_hit  (cand_hit[2*g]),
      .break_hit (cand_hit[2*g+1])
    );

    assign cand_key[2*g]   = new_keys[g];
    assign cand_key[2*g+1] = prev_keys_r[g];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < KEY_SLOTS; i++) prev_keys_r[i] <= '0;
      prev_mods_r <= '0;
    end else if (start) begin
      prev_keys_r <= new_keys;
      prev_mods_r <= in_modifier_bits;
    end
  end

  hid_kb_walker u_walker (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .load          (load),
    .cand_hit      (cand_hit),
    .cand_key      (cand_key),
    .mods_now      (in_modifier_bits),
    .mods_was      (prev_mods_r),
    .busy          (busy),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_scan_code (out_scan_code),
    .out_extended  (out_extended),
    .out_is_break  (out_is_break),
    .out_last      (out_last)
  );

endmodule
